// ----- rtl/spfec_pkg.sv -----
// ----------------------------------------------------------------------------
// spfec_pkg
// Shared types and constants for the serial packet framer with byte stuffing
// and additive checksum.
// ----------------------------------------------------------------------------
package spfec_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned MAX_PAYLOAD = 254;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BYTE_W-1:0] SYNC_RESET   = 8'hE0;
  localparam logic [BYTE_W-1:0] ESCAPE_RESET = 8'hD0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_TRAILER = 2'd2;

  // line byte slots of one item, in send order
  localparam int unsigned STEP_SYNC  = 0;
  localparam int unsigned STEP_DEST  = 1;
  localparam int unsigned STEP_LEN   = 2;
  localparam int unsigned STEP_ESC_D = 3;
  localparam int unsigned STEP_DATA  = 4;
  localparam int unsigned STEP_ESC_C = 5;
  localparam int unsigned STEP_CSUM  = 6;
  localparam int unsigned NUM_STEPS  = 7;

  typedef logic [NUM_STEPS-1:0] step_mask_t;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_value;
    logic [BYTE_W-1:0] escape_value;
    logic              escape_trailer;
  } cfg_t;

  // one classified item waiting for the back end
  typedef struct packed {
    step_mask_t        steps;
    logic [BYTE_W-1:0] dest;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] csum;
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t desc;
  } qwr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

endpackage

// ----- rtl/spfec_if.sv -----
// ----------------------------------------------------------------------------
// spfec_if
// Channel interfaces: payload items in, line bytes out, register writes.
// ----------------------------------------------------------------------------
interface spfec_item_if;
  logic       valid;
  logic       ready;
  logic [7:0] destination;
  logic [7:0] payload_count;
  logic [7:0] payload_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, destination, payload_count, payload_byte,
                  first_byte, last_byte, input ready);
  modport sink (input valid, destination, payload_count, payload_byte,
                first_byte, last_byte, output ready);
endinterface

interface spfec_line_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       run_end;
  logic       frame_end;

  modport source (output valid, line_byte, run_end, frame_end, input ready);
  modport sink (input valid, line_byte, run_end, frame_end, output ready);
endinterface

interface spfec_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/serial_packet_framer_escape_checksum_top.sv -----
// ----------------------------------------------------------------------------
// serial_packet_framer_escape_checksum_top
// Frames payload bytes for a multidrop serial link with byte stuffing and an
// additive checksum.
// ----------------------------------------------------------------------------
// Usage:
//   item: one payload byte per beat, with destination and count taken on the
//     beat marked first_byte, and last_byte closing the frame.
//   line: one line byte per beat; run_end marks the last byte caused by an
//     item, frame_end the byte that carries the checksum.
//   cfg:  register writes (sync, escape, trailer stuffing), always ready;
//     write them only while no item is in flight.
// Flow: with the back end idle, an accepted item is written into the queue and
//   its first line byte is then registered into the output stage. Each item
//   produces 1 to 7 line bytes, one per cycle while line.ready does not stall
//   the output; the sequencer's one byte per cycle sets the sustained rate.
//   Items are accepted every cycle while the two-entry queue has room.
// Reset: clears the checksum, the queue, the sequencer and the output stage,
//   and loads the sync (0xE0) and escape (0xD0) bytes with trailer stuffing
//   off.
// Stall: when line.ready is low the output byte holds; the queue fills and
//   item.ready drops once it is full.
// ----------------------------------------------------------------------------
module serial_packet_framer_escape_checksum_top (
  input  logic          clk,
  input  logic          rst,
  spfec_item_if.sink    item,
  spfec_line_if.source  line,
  spfec_cfg_if.sink     cfg
);

  spfec_pkg::cfg_t   regs;
  spfec_pkg::qwr_t   qwr;
  spfec_pkg::qstat_t qstat;
  spfec_pkg::desc_t  head;
  logic              pop;

  spfec_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  spfec_front u_front (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .regs  (regs),
    .qstat (qstat),
    .qwr   (qwr)
  );

  spfec_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .qwr   (qwr),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  spfec_back u_back (
    .clk   (clk),
    .rst   (rst),
    .regs  (regs),
    .head  (head),
    .qstat (qstat),
    .pop   (pop),
    .line  (line)
  );

endmodule

// ----- rtl/spfec_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// spfec_cfg_regs
// Configuration registers: sync byte, escape byte, trailer stuffing enable.
// ----------------------------------------------------------------------------
module spfec_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  spfec_cfg_if.sink          cfg,
  output spfec_pkg::cfg_t    regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sync_value     <= spfec_pkg::SYNC_RESET;
      regs.escape_value   <= spfec_pkg::ESCAPE_RESET;
      regs.escape_trailer <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        spfec_pkg::REG_SYNC:        regs.sync_value     <= cfg.data;
        spfec_pkg::REG_ESCAPE:      regs.escape_value   <= cfg.data;
        spfec_pkg::REG_ESC_TRAILER: regs.escape_trailer <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/spfec_front.sv -----
// ----------------------------------------------------------------------------
// spfec_front
// Accepts payload items, keeps the running checksum and classifies each item
// into the set of line bytes it causes.
// ----------------------------------------------------------------------------
module spfec_front (
  input  logic              clk,
  input  logic              rst,
  spfec_item_if.sink        item,
  input  spfec_pkg::cfg_t   regs,
  input  spfec_pkg::qstat_t qstat,
  output spfec_pkg::qwr_t   qwr
);

  logic [7:0] running_sum;
  logic [7:0] running_sum_next;
  logic [7:0] count_sat;
  logic [7:0] len;
  logic [7:0] base_sum;
  logic       data_stuff;
  logic       csum_stuff;
  logic       accept;

  assign item.ready = !qstat.full;
  assign accept     = item.valid && !qstat.full;

  always_comb begin
    count_sat = (item.payload_count > 8'(spfec_pkg::MAX_PAYLOAD)) ?
                8'(spfec_pkg::MAX_PAYLOAD) : item.payload_count;
    len       = count_sat + 8'd1;
    base_sum  = item.first_byte ? (item.destination + len) : running_sum;
    running_sum_next = base_sum + item.payload_byte;

    data_stuff = (item.payload_byte == regs.sync_value) ||
                 (item.payload_byte == regs.escape_value);
    csum_stuff = regs.escape_trailer &&
                 ((running_sum_next == regs.sync_value) ||
                  (running_sum_next == regs.escape_value));

    qwr.push = accept;
    qwr.desc.steps = '0;
    qwr.desc.steps[spfec_pkg::STEP_SYNC]  = item.first_byte;
    qwr.desc.steps[spfec_pkg::STEP_DEST]  = item.first_byte;
    qwr.desc.steps[spfec_pkg::STEP_LEN]   = item.first_byte;
    qwr.desc.steps[spfec_pkg::STEP_ESC_D] = data_stuff;
    qwr.desc.steps[spfec_pkg::STEP_DATA]  = 1'b1;
    qwr.desc.steps[spfec_pkg::STEP_ESC_C] = item.last_byte && csum_stuff;
    qwr.desc.steps[spfec_pkg::STEP_CSUM]  = item.last_byte;
    qwr.desc.dest = item.destination;
    qwr.desc.len  = len;
    qwr.desc.data = data_stuff ? (item.payload_byte - 8'd1) : item.payload_byte;
    qwr.desc.csum = csum_stuff ? (running_sum_next - 8'd1) : running_sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (accept) begin
      running_sum <= running_sum_next;
    end
  end

endmodule

// ----- rtl/spfec_queue.sv -----
// ----------------------------------------------------------------------------
// spfec_queue
// Short queue of classified items between the front and the back end.
// ----------------------------------------------------------------------------
module spfec_queue (
  input  logic               clk,
  input  logic               rst,
  input  spfec_pkg::qwr_t    qwr,
  input  logic               pop,
  output spfec_pkg::desc_t   head,
  output spfec_pkg::qstat_t  qstat
);

  spfec_pkg::desc_t                  entries [spfec_pkg::QUEUE_DEPTH];
  logic [spfec_pkg::QPTR_W-1:0]      wr_ptr;
  logic [spfec_pkg::QPTR_W-1:0]      rd_ptr;
  logic [spfec_pkg::QCNT_W-1:0]      fill;

  assign head        = entries[rd_ptr];
  assign qstat.empty = (fill == '0);
  assign qstat.full  = (fill == spfec_pkg::QCNT_W'(spfec_pkg::QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (qwr.push) begin
      entries[wr_ptr] <= qwr.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (qwr.push) begin
        wr_ptr <= (wr_ptr == spfec_pkg::QPTR_W'(spfec_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == spfec_pkg::QPTR_W'(spfec_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (qwr.push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !qwr.push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/spfec_back.sv -----
// ----------------------------------------------------------------------------
// spfec_back
// Walks the line byte slots of the head item, one byte per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module spfec_back (
  input  logic              clk,
  input  logic              rst,
  input  spfec_pkg::cfg_t   regs,
  input  spfec_pkg::desc_t  head,
  input  spfec_pkg::qstat_t qstat,
  output logic              pop,
  spfec_line_if.source      line
);

  spfec_pkg::step_mask_t rem;
  logic                  started;
  spfec_pkg::step_mask_t cur;
  spfec_pkg::step_mask_t sel;
  spfec_pkg::step_mask_t rest;
  logic [7:0]            byte_sel;
  logic                  emit;
  logic                  line_valid;
  logic [7:0]            line_byte;
  logic                  run_end;
  logic                  frame_end;

  assign line.valid     = line_valid;
  assign line.line_byte = line_byte;
  assign line.run_end   = run_end;
  assign line.frame_end = frame_end;

  always_comb begin
    cur  = started ? rem : head.steps;
    // lowest pending slot goes out next
    sel  = cur & (~cur + 1'b1);
    rest = cur & ~sel;
    emit = !qstat.empty && (!line_valid || line.ready);
    pop  = emit && (rest == '0);

    if (sel[spfec_pkg::STEP_SYNC]) begin
      byte_sel = regs.sync_value;
    end else if (sel[spfec_pkg::STEP_DEST]) begin
      byte_sel = head.dest;
    end else if (sel[spfec_pkg::STEP_LEN]) begin
      byte_sel = head.len;
    end else if (sel[spfec_pkg::STEP_DATA]) begin
      byte_sel = head.data;
    end else if (sel[spfec_pkg::STEP_CSUM]) begin
      byte_sel = head.csum;
    end else begin
      byte_sel = regs.escape_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started    <= 1'b0;
      rem        <= '0;
      line_valid <= 1'b0;
    end else begin
      if (emit) begin
        line_valid <= 1'b1;
        started    <= (rest != '0);
        rem        <= rest;
      end else if (line.ready) begin
        line_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      line_byte <= byte_sel;
      run_end   <= (rest == '0);
      frame_end <= sel[spfec_pkg::STEP_CSUM];
    end
  end

endmodule
